FILE: src/smie_pkg.sv
// Shared constants for the square-root market impact estimator.
// Stage counts, bucket thresholds and decimal scaling constants.
// No dependencies.
package smie_pkg;

  localparam int DIV_STAGES  = 32;
  localparam int SQRT_STAGES = 20;
  localparam int DEC_STAGES  = 24;

  typedef logic [6:0] coef_t;

  localparam logic [31:0] BKT_T1 = 32'd1000000;
  localparam logic [31:0] BKT_T2 = 32'd200000;
  localparam logic [31:0] BKT_T3 = 32'd50000;
  localparam logic [31:0] BKT_T4 = 32'd20000;

  localparam coef_t K_B1 = 7'd10;
  localparam coef_t K_B2 = 7'd20;
  localparam coef_t K_B3 = 7'd40;
  localparam coef_t K_B4 = 7'd60;
  localparam coef_t K_B5 = 7'd80;

  localparam logic [16:0] DEC_BASE = 17'd10000;

  localparam logic [7:0] REG_MIN_ADV  = 8'd0;
  localparam logic [7:0] REG_MIN_PART = 8'd1;
  localparam logic [7:0] REG_MAX_PART = 8'd2;

endpackage

FILE: src/smie_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Produces the 32-bit participation quotient; uses smie_pkg.
module smie_div import smie_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       in_rem,
  input  logic [31:0]       in_low,
  input  logic [31:0]       in_div,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [31:0]       out_quot,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [DIV_STAGES+1];
  logic [31:0]       rem  [DIV_STAGES+1];
  logic [31:0]       low  [DIV_STAGES+1];
  logic [31:0]       quo  [DIV_STAGES+1];
  logic [31:0]       dv   [DIV_STAGES+1];
  logic [SIDE_W-1:0] side [DIV_STAGES+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_rem;
  assign low[0]  = in_low;
  assign quo[0]  = 32'd0;
  assign dv[0]   = in_div;
  assign side[0] = in_side;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [32:0] trial;
    logic        take;

    assign trial = {rem[g], low[g][31]};
    assign take  = trial >= {1'b0, dv[g]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1]  <= take ? 32'(trial - {1'b0, dv[g]}) : trial[31:0];
        low[g+1]  <= {low[g][30:0], 1'b0};
        quo[g+1]  <= {quo[g][30:0], take};
        dv[g+1]   <= dv[g];
        side[g+1] <= side[g];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES];
  assign out_quot  = quo[DIV_STAGES];
  assign out_side  = side[DIV_STAGES];

endmodule

FILE: src/smie_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Takes the 40-bit scaled participation; uses smie_pkg.
module smie_sqrt import smie_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [39:0]       in_value,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [19:0]       out_root,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [SQRT_STAGES+1];
  logic [39:0]       val  [SQRT_STAGES+1];
  logic [20:0]       rem  [SQRT_STAGES+1];
  logic [19:0]       root [SQRT_STAGES+1];
  logic [SIDE_W-1:0] side [SQRT_STAGES+1];

  assign vld[0]  = in_valid;
  assign val[0]  = in_value;
  assign rem[0]  = 21'd0;
  assign root[0] = 20'd0;
  assign side[0] = in_side;

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [22:0] acc;
    logic [22:0] trial;
    logic        take;

    assign acc   = {rem[g], val[g][39:38]};
    assign trial = {1'b0, root[g], 2'b01};
    assign take  = acc >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1]  <= take ? 21'(acc - trial) : acc[20:0];
        root[g+1] <= {root[g][18:0], take};
        val[g+1]  <= {val[g][37:0], 2'b00};
        side[g+1] <= side[g];
      end
    end
  end

  assign out_valid = vld[SQRT_STAGES];
  assign out_root  = root[SQRT_STAGES];
  assign out_side  = side[SQRT_STAGES];

endmodule

FILE: src/smie_scale.sv
// Price scaling pipeline: floor(bps * price / 655360000), low 48 bits.
// Split multiply, shift by 2^16, then radix-4 division by 10000; uses smie_pkg.
module smie_scale import smie_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] in_bps,
  input  logic [47:0] in_price,
  output logic        out_valid,
  output logic [47:0] out_data
);

  logic        a_vld;
  logic [55:0] mul_hi;
  logic [55:0] mul_lo;
  logic        b_vld;
  logic [63:0] shifted;

  logic        d_vld [DEC_STAGES+1];
  logic [13:0] d_rem [DEC_STAGES+1];
  logic [47:0] d_low [DEC_STAGES+1];
  logic [47:0] d_quo [DEC_STAGES+1];

  logic [79:0] prod_sum;
  logic [16:0] top_part;
  logic [16:0] top_rem;

  assign prod_sum = {mul_hi, 24'd0} + {24'd0, mul_lo};

  // The top 16 bits are reduced mod 10000 first; their quotient lies above bit 47.
  always_comb begin
    top_part = {1'b0, shifted[63:48]};
    if (top_part >= DEC_BASE * 17'd6) begin
      top_rem = top_part - DEC_BASE * 17'd6;
    end else if (top_part >= DEC_BASE * 17'd5) begin
      top_rem = top_part - DEC_BASE * 17'd5;
    end else if (top_part >= DEC_BASE * 17'd4) begin
      top_rem = top_part - DEC_BASE * 17'd4;
    end else if (top_part >= DEC_BASE * 17'd3) begin
      top_rem = top_part - DEC_BASE * 17'd3;
    end else if (top_part >= DEC_BASE * 17'd2) begin
      top_rem = top_part - DEC_BASE * 17'd2;
    end else if (top_part >= DEC_BASE) begin
      top_rem = top_part - DEC_BASE;
    end else begin
      top_rem = top_part;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld    <= 1'b0;
      b_vld    <= 1'b0;
      d_vld[0] <= 1'b0;
    end else if (en) begin
      a_vld    <= in_valid;
      b_vld    <= a_vld;
      d_vld[0] <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_hi   <= in_bps * in_price[47:24];
      mul_lo   <= in_bps * in_price[23:0];
      shifted  <= prod_sum[79:16];
      d_rem[0] <= top_rem[13:0];
      d_low[0] <= shifted[47:0];
      d_quo[0] <= 48'd0;
    end
  end

  for (genvar g = 0; g < DEC_STAGES; g++) begin : g_dec
    logic [16:0] acc;
    logic [1:0]  digit;
    logic [16:0] sub;

    assign acc = {1'b0, d_rem[g], d_low[g][47:46]};

    always_comb begin
      if (acc >= DEC_BASE * 17'd3) begin
        digit = 2'd3;
        sub   = DEC_BASE * 17'd3;
      end else if (acc >= DEC_BASE * 17'd2) begin
        digit = 2'd2;
        sub   = DEC_BASE * 17'd2;
      end else if (acc >= DEC_BASE) begin
        digit = 2'd1;
        sub   = DEC_BASE;
      end else begin
        digit = 2'd0;
        sub   = 17'd0;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[g+1] <= 1'b0;
      end else if (en) begin
        d_vld[g+1] <= d_vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem[g+1] <= 14'(acc - sub);
        d_low[g+1] <= {d_low[g][45:0], 2'b00};
        d_quo[g+1] <= {d_quo[g][45:0], digit};
      end
    end
  end

  assign out_valid = d_vld[DEC_STAGES];
  assign out_data  = d_quo[DEC_STAGES];

endmodule

FILE: src/sqrt_market_impact_estimator.sv
// Top level of the square-root market impact estimator.
// Instantiates smie_div, smie_sqrt and smie_scale; uses smie_pkg.
//
// One order beat in, one impact beat out, in order. The pipeline accepts a
// beat every cycle while the output is not stalled. It is built from one
// input stage, 32 divider stages (one quotient bit each), a clamp stage,
// 20 square-root stages, a coefficient and cap stage, two multiply stages
// and 25 stages of radix-4 division by 10000. The whole pipeline holds while
// the output beat waits, so throughput is one beat per cycle whenever
// m_tready is high. Configuration writes are always ready and should be
// issued only while no order is in flight.
module sqrt_market_impact_estimator import smie_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // order_quantity[31:0], daily_volume[63:32], order_price[111:64],
  // impact_cap_bps[143:112]
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // impact_price[47:0]
  output logic [47:0]  m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int SIDE_W = 1 + $bits(coef_t) + 48 + 32;
  localparam int SQ_W   = $bits(coef_t) + 48 + 32;

  logic [31:0] min_adv;
  logic [31:0] min_part;
  logic [31:0] max_part;

  logic        en;

  logic [31:0] qraw;
  logic [31:0] mag;
  logic [31:0] vol_f;
  coef_t       coef;
  logic        ovf;

  logic              p_valid;
  logic [31:0]       p_rem;
  logic [31:0]       p_low;
  logic [31:0]       p_div;
  logic [SIDE_W-1:0] p_side;

  logic              dv_valid;
  logic [31:0]       dv_quot;
  logic [SIDE_W-1:0] dv_side;

  logic [31:0] clamp_val;
  logic        c_valid;
  logic [31:0] c_part;
  logic [SQ_W-1:0] c_side;

  logic            sq_valid;
  logic [19:0]     sq_root;
  logic [SQ_W-1:0] sq_side;

  coef_t       sq_coef;
  logic [47:0] sq_price;
  logic [31:0] sq_cap;
  logic [31:0] bps_raw;

  logic        b_valid;
  logic [31:0] b_bps;
  logic [47:0] b_price;
  logic [31:0] b_cap;

  assign en        = m_tready || !m_tvalid;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_adv  <= 32'd1;
      min_part <= 32'd0;
      max_part <= 32'd16777216;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_ADV:  min_adv  <= cfg_data;
        REG_MIN_PART: min_part <= cfg_data;
        REG_MAX_PART: max_part <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage: magnitude, volume floor, bucket and quotient overflow.
  always_comb begin
    qraw  = s_tdata[31:0];
    mag   = qraw[31] ? 32'(~qraw + 32'd1) : qraw;
    vol_f = (s_tdata[63:32] < min_adv) ? min_adv : s_tdata[63:32];
    if (vol_f == 32'd0) begin
      vol_f = 32'd1;
    end
    if (vol_f > BKT_T1) begin
      coef = K_B1;
    end else if (vol_f > BKT_T2) begin
      coef = K_B2;
    end else if (vol_f > BKT_T3) begin
      coef = K_B3;
    end else if (vol_f > BKT_T4) begin
      coef = K_B4;
    end else begin
      coef = K_B5;
    end
    // The quotient overflows 32 bits exactly when mag >= vol * 256.
    ovf = {8'd0, mag} >= {vol_f, 8'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_rem  <= {8'd0, mag[31:8]};
      p_low  <= {mag[7:0], 24'd0};
      p_div  <= vol_f;
      p_side <= {ovf, coef, s_tdata[111:64], s_tdata[143:112]};
    end
  end

  smie_div #(.SIDE_W(SIDE_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .in_rem    (p_rem),
    .in_low    (p_low),
    .in_div    (p_div),
    .in_side   (p_side),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // Saturate, then the lower bound, then the upper bound.
  always_comb begin
    clamp_val = dv_side[SIDE_W-1] ? 32'hFFFF_FFFF : dv_quot;
    if (clamp_val < min_part) begin
      clamp_val = min_part;
    end
    if (clamp_val > max_part) begin
      clamp_val = max_part;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_part <= clamp_val;
      c_side <= dv_side[SQ_W-1:0];
    end
  end

  smie_sqrt #(.SIDE_W(SQ_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_value  ({c_part, 8'd0}),
    .in_side   (c_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign sq_coef  = sq_side[SQ_W-1 -: $bits(coef_t)];
  assign sq_price = sq_side[79:32];
  assign sq_cap   = sq_side[31:0];
  assign bps_raw  = {25'd0, sq_coef} * {12'd0, sq_root};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_bps   <= (bps_raw > sq_cap) ? sq_cap : bps_raw;
      b_price <= sq_price;
      b_cap   <= sq_cap;
    end
  end

  smie_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .in_bps    (b_bps),
    .in_price  (b_price),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

  a_stall_blocks_input: assert property (@(posedge clk)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while output beat is stalled");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_bps_capped: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b_bps <= b_cap))
    else $error("impact bps above per-asset cap");

endmodule

FILE: bench/tb.sv
// Testbench for sqrt_market_impact_estimator: drives order beats, predicts
// each impact price in SystemVerilog and checks the output stream in order.
// Depends on smie_pkg and the estimator RTL.
`timescale 1ns / 1ps

module tb;
  import smie_pkg::*;

  localparam int LATENCY     = 82;
  localparam int MAX_ITEMS   = 4096;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] REG_UNUSED = 8'd7;

  typedef struct packed {
    logic [31:0] impact_cap_bps;
    logic [47:0] order_price;
    logic [31:0] daily_volume;
    logic [31:0] order_quantity;
  } order_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  sqrt_market_impact_estimator u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor's copy of the registers.
  logic [31:0] vol_floor = 32'd1;
  logic [31:0] part_lo = 32'd0;
  logic [31:0] part_hi = 32'd16777216;

  // Pending orders and expected results, each a store with read and write counts.
  order_t      pend_mem [MAX_ITEMS];
  int          pend_wr = 0;
  int          pend_rd = 0;
  logic [47:0] exp_mem [MAX_ITEMS];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          mismatches = 0;
  bit          failed = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_go = 0;
  bit          hold_done = 0;
  int          hold_cnt = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [47:0] predict_impact(order_t o);
    logic [31:0]  q;
    logic [31:0]  vol;
    logic [63:0]  mag;
    logic [63:0]  part;
    logic [63:0]  k;
    logic [63:0]  bps;
    logic [127:0] prod;
    q = o.order_quantity;
    mag = q[31] ? {32'd0, (~q) + 32'd1} : {32'd0, q};
    vol = o.daily_volume;
    if (vol < vol_floor) vol = vol_floor;
    if (vol == 0) vol = 32'd1;
    part = (mag << 24) / {32'd0, vol};
    if (part > 64'hFFFF_FFFF) part = 64'hFFFF_FFFF;
    if (part < part_lo) part = part_lo;
    if (part > part_hi) part = part_hi;
    if (vol > BKT_T1) k = K_B1;
    else if (vol > BKT_T2) k = K_B2;
    else if (vol > BKT_T3) k = K_B3;
    else if (vol > BKT_T4) k = K_B4;
    else k = K_B5;
    bps = k * int_sqrt(part << 8);
    if (bps > o.impact_cap_bps) bps = o.impact_cap_bps;
    prod = bps * o.order_price;
    return 48'(prod / 128'd655360000);
  endfunction

  // Driver: an offered beat stays up until accepted.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        exp_mem[exp_wr] = predict_impact(order_t'(s_tdata));
        exp_wr = exp_wr + 1;
        pend_rd = pend_rd + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pend_rd < pend_wr && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pend_mem[pend_rd];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (exp_rd == exp_wr) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: got %h", m_tdata);
        end else begin
          logic [47:0] exp_val;
          exp_val = exp_mem[exp_rd];
          exp_rd = exp_rd + 1;
          if (m_tdata !== exp_val) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10)
              $display("impact_price mismatch: expected %h got %h", exp_val, m_tdata);
          end
        end
      end
    end
  end

  // Receiver: random ready, and one long hold counted here once requested.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_go && !hold_done) begin
        m_tready <= 1'b0;
        if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
        hold_cnt <= hold_cnt + 1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [31:0] rand_volume();
    case ($urandom_range(7))
      0: return 32'($urandom_range(30));
      1: return 32'($urandom_range(25000, 15000));
      2: return 32'($urandom_range(60000, 40000));
      3: return 32'($urandom_range(250000, 150000));
      4: return 32'($urandom_range(1100000, 900000));
      5: return $urandom();
      6: return 32'($urandom_range(100));
      default: return $urandom() >> $urandom_range(31);
    endcase
  endfunction

  function automatic order_t rand_order();
    order_t o;
    o.order_quantity = $urandom() >> $urandom_range(31);
    if ($urandom_range(1)) o.order_quantity = -o.order_quantity;
    if ($urandom_range(15) == 0) o.order_quantity = 32'h8000_0000;
    o.daily_volume = rand_volume();
    o.order_price = 48'({$urandom(), $urandom()} >> (16 + $urandom_range(40)));
    o.impact_cap_bps = ($urandom_range(3) == 0) ? $urandom() >> $urandom_range(31)
                                                : 32'hFFFF_FFFF;
    return o;
  endfunction

  task automatic add_order(order_t o);
    pend_mem[pend_wr] = o;
    pend_wr = pend_wr + 1;
  endtask

  task automatic queue_order(logic [31:0] q, logic [31:0] v, logic [47:0] p,
                             logic [31:0] c);
    order_t o;
    o.order_quantity = q;
    o.daily_volume = v;
    o.order_price = p;
    o.impact_cap_bps = c;
    add_order(o);
  endtask

  task automatic drain();
    while (pend_rd != pend_wr || s_tvalid || exp_rd != exp_wr)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MIN_ADV) vol_floor = val;
    else if (idx == REG_MIN_PART) part_lo = val;
    else if (idx == REG_MAX_PART) part_hi = val;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    repeat (n) add_order(rand_order());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every bucket, saturation, zero volume.
    send_idle_pct = 26;
    recv_idle_pct = 73;
    queue_order(32'd0, 32'd0, 48'd0, 32'd0);
    queue_order(32'h7FFF_FFFF, 32'd0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_order(32'h8000_0000, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    queue_order(32'hFFFF_FFFF, 32'd1, 48'h1_0000, 32'hFFFF_FFFF);
    queue_order(32'd5000, 32'd2000000, 48'h64_0000, 32'hFFFF_FFFF);
    queue_order(-32'd5000, 32'd300000, 48'h64_0000, 32'hFFFF_FFFF);
    queue_order(32'd5000, 32'd60000, 48'h64_0000, 32'hFFFF_FFFF);
    queue_order(32'd5000, 32'd30000, 48'h64_0000, 32'hFFFF_FFFF);
    queue_order(32'd5000, 32'd20000, 48'h64_0000, 32'hFFFF_FFFF);
    queue_order(32'd5000, 32'd1000000, 48'h64_0000, 32'hFFFF_FFFF);
    queue_order(32'd5000, 32'd1000001, 48'h64_0000, 32'h1_0000);
    queue_order(32'd123, 32'd50000, 48'hFFFF_FFFF_FFFF, 32'd0);
    drain();

    // Zero volume floor, then crossed clamp bounds.
    write_reg(REG_MIN_ADV, 32'd0);
    write_reg(REG_MIN_PART, 32'hFFFF_FFFF);
    write_reg(REG_MAX_PART, 32'd0);
    write_reg(REG_UNUSED, 32'h1234_5678); // unknown index is ignored
    queue_order(32'd10, 32'd0, 48'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_order(32'hFFFF_FFFF, 32'd0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(400);
    drain();

    write_reg(REG_MIN_PART, 32'd0);
    write_reg(REG_MAX_PART, 32'hFFFF_FFFF);
    write_reg(REG_MIN_ADV, 32'hFFFF_FFFF);
    random_phase(400);
    drain();

    send_idle_pct = 73;
    recv_idle_pct = 26;
    write_reg(REG_MIN_ADV, 32'd1000);
    write_reg(REG_MIN_PART, 32'd1 << 16);
    write_reg(REG_MAX_PART, 32'd1 << 26);
    random_phase(400);
    drain();

    // Back-pressure: receiver holds off long while the sender keeps offering.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_MIN_ADV, 32'd1);
    write_reg(REG_MIN_PART, 32'd0);
    write_reg(REG_MAX_PART, 32'd16777216);
    hold_go = 1'b1;
    random_phase(400);
    drain();
    random_phase(330);
    drain();

    if (!failed && mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
